@@ hw/rtl/text_console_writer_top_defines.svh @@
// Assertion helpers used by the console top level.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [3:0] FG_RESET = 4'd15;
  localparam logic [3:0] BG_RESET = 4'd0;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_PUT,
    ST_READ,
    ST_RESP
  } state_e;

  // Store port request from the sequencer
  typedef struct packed {
    logic        we;
    logic [15:0] wdata;
  } wr_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcw_screen.sv @@
`default_nettype none

// Character cell store: one write and one registered read per cycle.
module tcw_screen #(
  parameter int unsigned DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire                  clk_i,
  input  wire tcw_pkg::wr_ctl_t wr_i,
  input  wire [AW-1:0]         waddr_i,
  input  wire [AW-1:0]         raddr_i,
  output logic [15:0]          rdata_o
);

  logic [15:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[waddr_i] <= wr_i.wdata;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/text_console_writer_top.sv @@
`default_nettype none
`include "text_console_writer_top_defines.svh"

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser: cmd; tdata: char_code, fill_color, cell_addr
// m_axis    out  m_axis_tvalid/m_axis_tready    cell_data, cursor_pos
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// Put: decode, the put state (cell write or newline), respond; a scroll first
// copies rows 1 to ROWS-1 up one row, a read state then a write state per
// cell, then fills the last row. Clear: decode, fill every cell, respond.
// Read: decode, read, respond; out of range or spare: decode, respond. After
// reset a clearing pass zeroes the store; no beat is taken meanwhile.
// One beat is worked at a time; a result waits in the output register while
// the next beat is accepted, and a second one holds the sequencer until taken.
module text_console_writer_top #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // slave side
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [1:0]  s_axis_tuser,  // cmd[1:0]
  input  wire  [23:0] s_axis_tdata,  // char_code[7:0], fill_color[11:8],
                                     // cell_addr[22:12], zero pad
  // master side
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cell_data[15:0], cursor_pos[26:16], zero pad
  // register writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [tcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [3:0]  cfg_data_i
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned LAST  = COLUMNS * (ROWS - 1);     // start of last row
  localparam int unsigned AW    = $clog2(CELLS);            // store index
  localparam int unsigned CW    = $clog2(CELLS + 1);        // cursor, may be CELLS
  localparam int unsigned COLW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned PW    = (CW > 11) ? CW : 11;      // compare width

  tcw_pkg::state_e state_q, state_d;

  // latched beat
  logic [1:0]  cmd_q;
  logic [7:0]  char_q;
  logic [3:0]  color_q;
  logic [10:0] addr_q;

  logic [3:0]      fg_q, bg_q;
  logic [7:0]      fill_q, fill_d;
  logic [CW-1:0]   cursor_q, cursor_d;
  logic [COLW-1:0] col_q, col_d;      // column of the cursor, kept to skip a modulo
  logic [AW-1:0]   idx_q, idx_d;      // sweep counter
  logic [15:0]     res_q, res_d;

  logic        out_valid_q;
  logic [31:0] out_data_q;

  tcw_pkg::wr_ctl_t wr;
  logic [AW-1:0]    waddr, raddr;
  logic [15:0]      rdata;

  logic            in_fire;
  logic            out_free;
  logic [PW-1:0]   addr_ext;
  logic            addr_ok;
  logic [PW+10:0]  cursor_ext;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign addr_ext = PW'(addr_q);
  assign addr_ok  = addr_ext < PW'(CELLS);
  assign cursor_ext = (PW + 11)'(cursor_q);

  assign s_axis_tready = (state_q == tcw_pkg::ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  tcw_screen #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_screen (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .waddr_i (waddr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // sequencer: one store access per cycle, shared index adder
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    cursor_d = cursor_q;
    col_d    = col_q;
    idx_d    = idx_q;
    res_d    = res_q;
    wr.we    = 1'b0;
    wr.wdata = {fill_q, fill_q};
    waddr    = idx_q;
    raddr    = idx_q;

    case (state_q)
      tcw_pkg::ST_INIT: begin
        wr.we = 1'b1;
        idx_d = idx_q + AW'(1);
        if (idx_q == AW'(CELLS - 1)) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = tcw_pkg::ST_DECODE;
        end
      end
      tcw_pkg::ST_DECODE: begin
        res_d = '0;
        idx_d = '0;
        case (cmd_q)
          tcw_pkg::CMD_PUT: begin
            if (cursor_q >= CW'(CELLS)) begin
              state_d = tcw_pkg::ST_SCROLL_RD;
            end else begin
              state_d = tcw_pkg::ST_PUT;
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            fill_d   = {color_q, color_q};
            cursor_d = '0;
            col_d    = '0;
            state_d  = tcw_pkg::ST_FILL;
          end
          tcw_pkg::CMD_READ: begin
            raddr = addr_ext[AW-1:0];
            if (addr_ok) begin
              state_d = tcw_pkg::ST_READ;
            end else begin
              state_d = tcw_pkg::ST_RESP;
            end
          end
          default: begin
            state_d = tcw_pkg::ST_RESP;
          end
        endcase
      end
      tcw_pkg::ST_SCROLL_RD: begin
        raddr   = idx_q + AW'(COLUMNS);
        state_d = tcw_pkg::ST_SCROLL_WR;
      end
      tcw_pkg::ST_SCROLL_WR: begin
        wr.we    = 1'b1;
        wr.wdata = rdata;
        idx_d    = idx_q + AW'(1);
        if (idx_q == AW'(LAST - 1)) begin
          cursor_d = CW'(LAST);
          col_d    = '0;
          state_d  = tcw_pkg::ST_FILL;
        end else begin
          state_d = tcw_pkg::ST_SCROLL_RD;
        end
      end
      tcw_pkg::ST_FILL: begin
        wr.we = 1'b1;
        idx_d = idx_q + AW'(1);
        if (idx_q == AW'(CELLS - 1)) begin
          if (cmd_q == tcw_pkg::CMD_PUT) begin
            state_d = tcw_pkg::ST_PUT;
          end else begin
            state_d = tcw_pkg::ST_RESP;
          end
        end
      end
      tcw_pkg::ST_PUT: begin
        waddr = cursor_q[AW-1:0];
        if (char_q == tcw_pkg::NEWLINE_CODE) begin
          // row start plus one row never passes CELLS here
          cursor_d = cursor_q - CW'(col_q) + CW'(COLUMNS);
          col_d    = '0;
        end else begin
          wr.we    = 1'b1;
          wr.wdata = {bg_q, fg_q, char_q};
          cursor_d = cursor_q + CW'(1);
          if (col_q == COLW'(COLUMNS - 1)) begin
            col_d = '0;
          end else begin
            col_d = col_q + COLW'(1);
          end
        end
        state_d = tcw_pkg::ST_RESP;
      end
      tcw_pkg::ST_READ: begin
        res_d   = rdata;
        state_d = tcw_pkg::ST_RESP;
      end
      tcw_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tcw_pkg::ST_INIT;
      fill_q   <= '0;
      cursor_q <= '0;
      col_q    <= '0;
      idx_q    <= '0;
      fg_q     <= tcw_pkg::FG_RESET;
      bg_q     <= tcw_pkg::BG_RESET;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      cursor_q <= cursor_d;
      col_q    <= col_d;
      idx_q    <= idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == tcw_pkg::CFG_FG_COLOR) begin
          fg_q <= cfg_data_i;
        end else if (cfg_index_i == tcw_pkg::CFG_BG_COLOR) begin
          bg_q <= cfg_data_i;
        end
      end
    end
  end

  // beat payload and pending result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= s_axis_tuser;
      char_q  <= s_axis_tdata[7:0];
      color_q <= s_axis_tdata[11:8];
      addr_q  <= s_axis_tdata[22:12];
    end
    res_q <= res_d;
    if (state_q == tcw_pkg::ST_RESP && out_free) begin
      out_data_q <= {5'd0, cursor_ext[10:0], res_q};
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == tcw_pkg::ST_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  `TCW_ASSERT_NEXT(a_busy_after_beat, in_fire, !s_axis_tready, "ready right after a beat")
  `TCW_ASSERT_NOW(a_cursor_range, 1'b1, cursor_q <= CW'(CELLS), "cursor past end of screen")
  `TCW_ASSERT_NOW(a_col_range, 1'b1, col_q <= COLW'(COLUMNS - 1), "column out of range")
  `TCW_ASSERT_NOW(a_sweep_fill,
                  wr.we && (state_q == tcw_pkg::ST_FILL || state_q == tcw_pkg::ST_INIT),
                  wr.wdata == {fill_q, fill_q}, "sweep writes non-fill data")
  `TCW_ASSERT_NOW(a_result_from_resp, $rose(out_valid_q),
                  $past(state_q) == tcw_pkg::ST_RESP, "result without response state")

endmodule

`default_nettype wire

@@ test/text_console_writer_top_tb.sv @@
`timescale 1ns / 100ps

// Console writer bench: put/clear/read commands go in on s_axis, each beat
// gives exactly one result beat on m_axis. A shadow screen, cursor and color
// set here predict results not typed by hand; results are matched in order.
module text_console_writer_top_tb;

  localparam int unsigned COLUMNS    = tcw_pkg::COLUMNS_DEF;
  localparam int unsigned ROWS       = tcw_pkg::ROWS_DEF;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  // First cell of the bottom row; a scroll parks the cursor here.
  localparam int unsigned LAST_ROW_BASE = COLUMNS * (ROWS - 1);

  // Codes the package leaves out: the spare command and a register index
  // beyond the two real ones. Both must be harmless.
  localparam logic [1:0]                    CMD_UNUSED    = 2'd3;
  localparam logic [tcw_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd2;

  localparam int PHASE_ITEMS    = 175;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_SETTLE     = 100;
  // Longest quiet stretch of a correct run is one scroll with the receiver
  // held off on top; the post-reset clearing pass is shorter.
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PRINT_CAP      = 40;
  localparam int N_ROWS         = 30;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [3:0]  fill_color;
    logic [10:0] cell_addr;
  } console_req_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [10:0] cursor_pos;
  } console_reply_t;

  // Directed row: a request, how many times to send it, and, where it is
  // obvious, the result typed in by hand.
  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic [3:0]  color;
    logic [10:0] addr;
    int unsigned reps;
    bit          typed;
    logic [15:0] data;
    logic [10:0] cursor;
  } stim_row_t;

  logic        clk_i;
  logic        rst_n     = 1'b0;
  logic        s_valid   = 1'b0;
  logic [1:0]  s_user    = '0;
  logic [23:0] s_data    = '0;
  logic        m_ready   = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [3:0]  cfg_data  = '0;

  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [31:0] m_axis_tdata;
  wire         cfg_ready_o;

  // Shadow of the block's state
  logic [15:0] screen_model [CELL_COUNT];
  int unsigned cursor_model;
  logic [7:0]  fill_model;
  logic [3:0]  fg_model;
  logic [3:0]  bg_model;

  console_reply_t reply_q [$];  // results owed by the block, oldest first
  stim_row_t      stim_rows [N_ROWS];

  int   mismatch_count = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  bit   hold_go        = 1'b0;
  logic holding        = 1'b0;

  text_console_writer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_user),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Advance the shadow console by one command and return the result beat.
  function automatic console_reply_t next_console_reply(input console_req_t req);
    console_reply_t r;
    int unsigned k;
    int unsigned nxt;
    r = '0;
    case (req.cmd)
      tcw_pkg::CMD_PUT: begin
        // past the end: scroll everything up one row first
        if (cursor_model >= CELL_COUNT) begin
          for (k = 0; k < LAST_ROW_BASE; k++) screen_model[k] = screen_model[k + COLUMNS];
          for (k = LAST_ROW_BASE; k < CELL_COUNT; k++) screen_model[k] = {fill_model, fill_model};
          cursor_model = LAST_ROW_BASE;
        end
        if (req.char_code == tcw_pkg::NEWLINE_CODE) begin
          nxt = cursor_model + COLUMNS;
          nxt = nxt - (nxt % COLUMNS);
          cursor_model = (nxt > CELL_COUNT) ? CELL_COUNT : nxt;
        end else begin
          screen_model[cursor_model] = {bg_model, fg_model, req.char_code};
          cursor_model++;
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        fill_model = {req.fill_color, req.fill_color};
        for (k = 0; k < CELL_COUNT; k++) screen_model[k] = {fill_model, fill_model};
        cursor_model = 0;
      end
      tcw_pkg::CMD_READ: begin
        if (req.cell_addr < CELL_COUNT) r.cell_data = screen_model[req.cell_addr];
      end
      default: ;  // spare command: no effect
    endcase
    r.cursor_pos = cursor_model[10:0];
    return r;
  endfunction

  // Mostly puts of any byte code, with plenty of newlines so the screen fills and
  // scrolls; reads lean toward the cells just written; clears are rare so
  // the cursor gets to the bottom between them.
  function automatic console_req_t random_console_req();
    console_req_t r;
    int pick;
    int unsigned lo;
    r.char_code  = 8'($urandom_range(255));
    r.fill_color = 4'($urandom_range(15));
    r.cell_addr  = 11'($urandom_range(2047));
    pick = $urandom_range(199);
    if (pick < 130) begin
      r.cmd = tcw_pkg::CMD_PUT;
      if ($urandom_range(3) == 0) r.char_code = tcw_pkg::NEWLINE_CODE;
    end else if (pick < 180) begin
      r.cmd = tcw_pkg::CMD_READ;
      if ($urandom_range(9) < 6 && cursor_model != 0) begin
        lo = (cursor_model > 160) ? cursor_model - 160 : 0;
        r.cell_addr = 11'($urandom_range(cursor_model - 1, lo));
      end
    end else if (pick < 199) begin
      r.cmd = CMD_UNUSED;
    end else begin
      r.cmd = tcw_pkg::CMD_CLEAR;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("%0t ns  mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Called at a clock edge; returns at the edge where the beat was taken.
  task automatic send_request(input console_req_t req, input bit typed,
                              input console_reply_t typed_reply);
    console_reply_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= req.cmd;
    s_data  <= {1'b0, req.cell_addr, req.fill_color, req.char_code};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = next_console_reply(req);
    reply_q.push_back(typed ? typed_reply : predicted);
  endtask

  // Drop valid and let every owed result come back.
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Back-to-back register writes, valid held high across them. The spare
  // index, when poked, must leave both colors alone.
  task automatic program_colors(input logic [3:0] fg, input logic [3:0] bg,
                                input bit poke_spare);
    logic [tcw_pkg::CFG_IDX_W-1:0] idx [3];
    logic [3:0] val [3];
    int n;
    idx = '{tcw_pkg::CFG_FG_COLOR, tcw_pkg::CFG_BG_COLOR, CFG_SPARE_IDX};
    val = '{fg, bg, ~fg};
    for (n = 0; n < (poke_spare ? 3 : 2); n++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[n];
      cfg_data  <= val[n];
      do @(posedge clk_i); while (!cfg_ready_o);
      if (idx[n] == tcw_pkg::CFG_FG_COLOR) fg_model = val[n];
      else if (idx[n] == tcw_pkg::CFG_BG_COLOR) bg_model = val[n];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_reply(input logic [31:0] beat);
    console_reply_t want;
    if (reply_q.size() == 0) begin
      report_mismatch($sformatf("result beat %h with nothing owed", beat));
      return;
    end
    want = reply_q.pop_front();
    if (beat[15:0] !== want.cell_data)
      report_mismatch($sformatf("cell_data %h, want %h", beat[15:0], want.cell_data));
    if (beat[26:16] !== want.cursor_pos)
      report_mismatch($sformatf("cursor_pos %0d, want %0d", beat[26:16], want.cursor_pos));
  endtask

  // Result side: check on every taken beat, then pick next cycle's ready.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_ready) check_reply(m_axis_tdata);
      m_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing and
  // the block backs up into s_axis_tready.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    holding <= 1'b0;
  end

  // Watchdog: any handshake on any channel restarts the count.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) ||
          (cfg_valid && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int k;
    int row;
    int unsigned rep;
    int p;
    int n;
    console_req_t req;
    console_reply_t typed_reply;

    for (k = 0; k < CELL_COUNT; k++) screen_model[k] = '0;
    cursor_model = 0;
    fill_model   = '0;
    fg_model     = tcw_pkg::FG_RESET;
    bg_model     = tcw_pkg::BG_RESET;

    // Directed rows, reset colors (white on black = attribute 8'h0F).
    //  cmd                  char    clr    addr      reps typ data      cursor
    stim_rows = '{
      // fresh store, last cell, out of range, spare cmd
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd0,    1, 1, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_READ,   8'hFF, 4'hF, 11'd1999, 1, 1, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd2047, 1, 1, 16'h0000, 11'd0},
      '{CMD_UNUSED,          8'hFF, 4'hF, 11'd2047, 1, 1, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_PUT,    8'h41, 4'h0, 11'd0,    1, 1, 16'h0000, 11'd1},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd0,    1, 1, 16'h0F41, 11'd1},
      '{tcw_pkg::CMD_PUT,    8'hFF, 4'h0, 11'd0,    1, 1, 16'h0000, 11'd2},
      '{tcw_pkg::CMD_PUT,    8'h00, 4'hF, 11'd2047, 1, 1, 16'h0000, 11'd3},
      '{tcw_pkg::CMD_PUT,    tcw_pkg::NEWLINE_CODE, 4'h0, 11'd0, 1, 1, 16'h0000, 11'd80},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd1,    1, 1, 16'h0FFF, 11'd80},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd2,    1, 1, 16'h0F00, 11'd80},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd3,    1, 1, 16'h0000, 11'd80},
      '{tcw_pkg::CMD_CLEAR,  8'h00, 4'hF, 11'd0,    1, 1, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd1999, 1, 1, 16'hFFFF, 11'd0},
      '{tcw_pkg::CMD_CLEAR,  8'h00, 4'h0, 11'd0,    1, 1, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd0,    1, 1, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_CLEAR,  8'h00, 4'h6, 11'd0,    1, 1, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_PUT,    8'h31, 4'h0, 11'd0,    1, 1, 16'h0000, 11'd1},
      // down to the last row
      '{tcw_pkg::CMD_PUT,    tcw_pkg::NEWLINE_CODE, 4'h0, 11'd0, 24, 0, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_PUT,    8'h7E, 4'h0, 11'd0,    1, 0, 16'h0000, 11'd0},
      // past the end
      '{tcw_pkg::CMD_PUT,    tcw_pkg::NEWLINE_CODE, 4'h0, 11'd0, 1, 1, 16'h0000, 11'd2000},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd2047, 1, 1, 16'h0000, 11'd2000},
      // scroll, then write
      '{tcw_pkg::CMD_PUT,    8'h5A, 4'h0, 11'd0,    1, 0, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd1920, 1, 0, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd1921, 1, 0, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd0,    1, 0, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd1840, 1, 0, 16'h0000, 11'd0},
      // second newline scrolls
      '{tcw_pkg::CMD_PUT,    tcw_pkg::NEWLINE_CODE, 4'h0, 11'd0, 1, 0, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_PUT,    tcw_pkg::NEWLINE_CODE, 4'h0, 11'd0, 1, 0, 16'h0000, 11'd0},
      '{tcw_pkg::CMD_READ,   8'h00, 4'h0, 11'd1999, 1, 0, 16'h0000, 11'd0}
    };

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed part: no idling either side.
    for (row = 0; row < N_ROWS; row++) begin
      req = {stim_rows[row].cmd, stim_rows[row].ch, stim_rows[row].color,
             stim_rows[row].addr};
      typed_reply = {stim_rows[row].data, stim_rows[row].cursor};
      for (rep = 0; rep < stim_rows[row].reps; rep++)
        send_request(req, stim_rows[row].typed, typed_reply);
    end

    // Random phases; colors change only with the pipe empty.
    for (p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          program_colors(4'h0, 4'h0, 1'b1);
        end
        1: begin
          send_idle_pct = 46; recv_stall_pct = 0;
          program_colors(4'hF, 4'hF, 1'b0);
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 46;
          program_colors(4'($urandom_range(15)), 4'($urandom_range(15)), 1'b0);
        end
        default: begin
          send_idle_pct = 20; recv_stall_pct = 20;
          program_colors(4'h0, 4'hF, 1'b0);
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 40) hold_go = 1'b1;  // back-pressure burst
        if (p == 1 && n == 90) wait_drained();  // sender waits for a dry pipe
        send_request(random_console_req(), 1'b0, '0);
      end
    end

    s_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (END_SETTLE) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
